// ===== design/bld_pkg.sv =====
`default_nettype none

package bld_pkg;

  // coordinate width fixed by the port definition
  localparam int COORD_W        = 6;
  localparam int COORD_SPAN_DEF = 64;
  localparam int CMD_DEPTH      = 2;

  // signed error term: covers -2*63 .. 2*63
  localparam int ERR_W = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // one classified line command
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    logic   x_dec;    // x walks downward
    logic   y_dec;    // y walks downward
    logic   x_major;  // x is the stepping axis
    coord_t major;    // major-axis span
    coord_t minor;    // minor-axis span
  } line_cmd_t;

  // walker states
  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } walk_state_t;

  // queue control from walker
  typedef struct packed {
    logic pop;
  } q_ctl_t;

endpackage

`default_nettype wire

// ===== design/bld_front.sv =====
`default_nettype none

module bld_front
  import bld_pkg::*;
#(
  parameter int COORD_SPAN = COORD_SPAN_DEF
) (
  input  wire logic      [COORD_W-1:0] in_start_x,
  input  wire logic      [COORD_W-1:0] in_start_y,
  input  wire logic      [COORD_W-1:0] in_end_x,
  input  wire logic      [COORD_W-1:0] in_end_y,
  output line_cmd_t                    cmd
);

  localparam coord_t COORD_MAX = COORD_W'(COORD_SPAN - 1);

  coord_t sx, sy, ex, ey;
  coord_t span_x, span_y;
  logic   x_dec, y_dec, x_major;

  // saturate coordinates to the configured span
  always_comb begin
    sx = (in_start_x > COORD_MAX) ? COORD_MAX : in_start_x;
    sy = (in_start_y > COORD_MAX) ? COORD_MAX : in_start_y;
    ex = (in_end_x   > COORD_MAX) ? COORD_MAX : in_end_x;
    ey = (in_end_y   > COORD_MAX) ? COORD_MAX : in_end_y;
  end

  // direction and absolute spans
  always_comb begin
    x_dec   = ex < sx;
    y_dec   = ey < sy;
    span_x  = x_dec ? (sx - ex) : (ex - sx);
    span_y  = y_dec ? (sy - ey) : (ey - sy);
    x_major = span_x >= span_y;
  end

  // classified command
  always_comb begin
    cmd.x0      = sx;
    cmd.y0      = sy;
    cmd.x_dec   = x_dec;
    cmd.y_dec   = y_dec;
    cmd.x_major = x_major;
    cmd.major   = x_major ? span_x : span_y;
    cmd.minor   = x_major ? span_y : span_x;
  end

endmodule

`default_nettype wire

// ===== design/bld_queue.sv =====
`default_nettype none

module bld_queue
  import bld_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  line_cmd_t      push_cmd,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output line_cmd_t      head_cmd
);

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  line_cmd_t          mem [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full     = count_r == CNT_W'(CMD_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/bld_walker.sv =====
`default_nettype none

module bld_walker
  import bld_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               invert_mode,
  output q_ctl_t                  q_ctl_o,
  input  wire logic               q_empty,
  input  line_cmd_t               head_cmd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [COORD_W-1:0] out_dot_x,
  output logic      [COORD_W-1:0] out_dot_y,
  output logic                    out_dot_value,
  output logic                    out_last_dot
);

  walk_state_t state_r, state_nxt;

  line_cmd_t cmd_r, cmd_nxt;
  coord_t    x_r, x_nxt, y_r, y_nxt, rem_r, rem_nxt;
  err_t      err_r, err_nxt, err_add, two_major, two_minor;

  logic   ov_r, ov_nxt;
  coord_t ox_r, ox_nxt, oy_r, oy_nxt;
  logic   oval_r, oval_nxt, olast_r, olast_nxt;

  logic   slot_free, emit, pop;
  coord_t x_step, y_step;

  assign slot_free = !ov_r || !out_stall;
  assign two_major = $signed({2'b00, cmd_r.major, 1'b0});
  assign two_minor = $signed({2'b00, cmd_r.minor, 1'b0});
  assign err_add   = err_r + two_minor;
  assign x_step    = cmd_r.x_dec ? (x_r - 1'b1) : (x_r + 1'b1);
  assign y_step    = cmd_r.y_dec ? (y_r - 1'b1) : (y_r + 1'b1);

  // state and walker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    rem_r   <= rem_nxt;
    err_r   <= err_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

  // fetch, step and output register control
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    rem_nxt   = rem_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && out_stall;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    pop       = 1'b0;
    emit      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // take the next command from the queue
        if (!q_empty) begin
          pop       = 1'b1;
          cmd_nxt   = head_cmd;
          x_nxt     = head_cmd.x0;
          y_nxt     = head_cmd.y0;
          rem_nxt   = head_cmd.major;
          err_nxt   = -$signed({3'b000, head_cmd.major});
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        emit = slot_free;
        if (emit) begin
          ov_nxt    = 1'b1;
          ox_nxt    = x_r;
          oy_nxt    = y_r;
          oval_nxt  = !invert_mode;
          olast_nxt = rem_r == '0;
          // advance along the major axis, minor when error goes non-negative
          if (cmd_r.x_major) begin
            x_nxt = x_step;
            if (err_add >= 0) begin
              y_nxt   = y_step;
              err_nxt = err_add - two_major;
            end else begin
              err_nxt = err_add;
            end
          end else begin
            y_nxt = y_step;
            if (err_add >= 0) begin
              x_nxt   = x_step;
              err_nxt = err_add - two_major;
            end else begin
              err_nxt = err_add;
            end
          end
          if (rem_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt = rem_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign q_ctl_o.pop   = pop;

  assign out_valid     = ov_r;
  assign out_dot_x     = ox_r;
  assign out_dot_y     = oy_r;
  assign out_dot_value = oval_r;
  assign out_last_dot  = olast_r;

endmodule

`default_nettype wire

// ===== design/bresenham_line_dot_generator.sv =====
`default_nettype none

// Bresenham line dot generator. Each accepted input word is one line command
// (start and end point, coordinates saturated to COORD_SPAN-1); the block
// returns the line's dots in order from start to end, one output word per dot,
// with out_last_dot set on the final one. A zero-length line gives one dot.
// out_dot_value is 1 (set) or 0 (clear) when invert mode is on. A line of
// major-axis span N gives N+1 dots. The walker emits one dot per cycle while
// out_stall does not hold back a pending dot, and before each line it passes
// through its idle state to fetch the command from its two-entry command queue.
// The front end keeps accepting commands until that queue is full.
// Write invert mode through cfg_we/cfg_wdata only while no line is in flight.

module bresenham_line_dot_generator
  import bld_pkg::*;
#(
  parameter int COORD_SPAN = COORD_SPAN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [COORD_W-1:0] in_start_x,
  input  wire logic [COORD_W-1:0] in_start_y,
  input  wire logic [COORD_W-1:0] in_end_x,
  input  wire logic [COORD_W-1:0] in_end_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [COORD_W-1:0] out_dot_x,
  output logic      [COORD_W-1:0] out_dot_y,
  output logic                    out_dot_value,
  output logic                    out_last_dot
);

  logic      invert_mode_r;
  line_cmd_t front_cmd, head_cmd;
  logic      q_full, q_empty;
  q_ctl_t    q_ctl;

  // invert mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_mode_r <= 1'b0;
    end else if (cfg_we) begin
      invert_mode_r <= cfg_wdata;
    end
  end

  assign in_stall = q_full;

  bld_front #(
    .COORD_SPAN (COORD_SPAN)
  ) u_front (
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .cmd        (front_cmd)
  );

  bld_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_ctl.pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  bld_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .invert_mode   (invert_mode_r),
    .q_ctl_o       (q_ctl),
    .q_empty       (q_empty),
    .head_cmd      (head_cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dot_x     (out_dot_x),
    .out_dot_y     (out_dot_y),
    .out_dot_value (out_dot_value),
    .out_last_dot  (out_last_dot)
  );

endmodule

`default_nettype wire
